// ----- hdl/nmea_ck_pkg.sv -----
package nmea_ck_pkg;

    // Default number of characters in the numeric field
    localparam int FIELD_CHARS_DEF = 4;

    // Field offset after reset
    localparam logic [7:0] OFFSET_RESET = 8'd8;

    // ASCII codes
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_HEX_BIAS = 8'h37;   // 'A' - 10

    // Checksum characters still expected
    typedef logic [1:0] cs_left_t;
    localparam cs_left_t CS_NONE = 2'd0;
    localparam cs_left_t CS_LAST = 2'd1;
    localparam cs_left_t CS_BOTH = 2'd2;

    // Output range in thousandths
    localparam int MILLI_POS_MAX = 16777215;
    localparam int MILLI_NEG_MAG = 16777216;
    localparam logic signed [24:0] MILLI_MAX = 25'sh0FFFFFF;
    localparam logic signed [24:0] MILLI_MIN = 25'sh1000000;

    // Upper-case hex character of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'h0, nib};
        if (nib < 4'd10)
        begin
            hex_digit = CH_ZERO + ext;
        end
        else
        begin
            hex_digit = CH_HEX_BIAS + ext;
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- hdl/nmea_checksum_field_extract.sv -----
// NMEA sentence checksum check with numeric field extraction.
//
// Input channel: one received character per item on rx_byte (in_valid /
// in_stall). '$' opens a sentence, '*' starts the two hex checksum
// characters, CR starts a new line.
// Output channel: one item after the second checksum character, carrying
// checksum_ok, computed_checksum and field_value_milli (out_valid /
// out_stall). Characters that produce no result produce no output item.
// Config channel: cfg_valid / cfg_ready write field_offset, the line
// position of the first field character. cfg_ready is always high; write
// only while no item is in flight.
// Pipeline: after the second checksum character is accepted, the result
// is registered in the snapshot, parse and scale stages in turn.
// Throughput: one character per cycle while in_stall is low, with the
// state updated on each accepted character.
// Reset: checksum state, line position and pipeline are cleared and
// field_offset returns to 8.
// Stall: a stalled result holds; the stages behind it keep filling and
// in_stall rises only once every stage holds a result.
module nmea_checksum_field_extract #(
    parameter int FIELD_CHARS = nmea_ck_pkg::FIELD_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               checksum_ok,
    output logic [7:0]         computed_checksum,
    output logic signed [24:0] field_value_milli,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_field_offset
);

    // Integer part of FIELD_CHARS digits
    localparam int IP_W  = $clog2(10 ** FIELD_CHARS);
    // ip * 1000 + fraction
    localparam int MAG_W = IP_W + 11;
    localparam int CMP_W = (MAG_W > 26) ? MAG_W : 26;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [7:0] offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= nmea_ck_pkg::OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_reg <= cfg_field_offset;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s_valid_reg;
    logic p_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic p_free;
    logic s_free;
    logic in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign p_free    = !p_valid_reg || out_free;
    assign s_free    = !s_valid_reg || p_free;
    assign in_stall  = !s_free;
    assign in_accept = in_valid && s_free;

    // ------------------------------------------------------------------
    // Per-character state update
    // ------------------------------------------------------------------
    logic [7:0]             acc_reg, acc_next;
    nmea_ck_pkg::cs_left_t  left_reg, left_next;
    logic [7:0]             first_reg, first_next;
    logic [7:0]             pos_reg, pos_next;
    logic [7:0]             field_chars_reg [FIELD_CHARS];
    logic [7:0]             chars_next [FIELD_CHARS];
    logic [7:0]             snap_chars [FIELD_CHARS];
    logic [FIELD_CHARS-1:0] wr_en;
    logic                   emit;
    logic                   ok_now;
    logic                   is_cr;

    assign is_cr = (rx_byte == nmea_ck_pkg::CH_CR);

    always_comb
    begin
        pos_next = pos_reg;
        if (is_cr)
        begin
            pos_next = 8'd0;
        end
        else if (pos_reg != 8'hFF)
        begin
            pos_next = pos_reg + 8'd1;
        end
    end

    // Field characters: each entry is written when the line reaches its position
    always_comb
    begin
        for (int i = 0; i < FIELD_CHARS; i++)
        begin
            wr_en[i] = !is_cr && (pos_reg != 8'hFF)
                       && ({1'b0, pos_reg} == ({1'b0, offset_reg} + 9'(i)));
            chars_next[i] = wr_en[i] ? rx_byte : field_chars_reg[i];
            // positions not yet reached in this line read as end of text
            snap_chars[i] = (({1'b0, offset_reg} + 9'(i)) < {1'b0, pos_next})
                            ? chars_next[i] : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FIELD_CHARS; i++)
        begin
            if (in_accept && wr_en[i])
            begin
                field_chars_reg[i] <= rx_byte;
            end
        end
    end

    assign ok_now = (first_reg == nmea_ck_pkg::hex_digit(acc_reg[7:4]))
                    && (rx_byte == nmea_ck_pkg::hex_digit(acc_reg[3:0]));

    always_comb
    begin
        acc_next   = acc_reg;
        left_next  = left_reg;
        first_next = first_reg;
        emit       = 1'b0;
        if (rx_byte == nmea_ck_pkg::CH_DOLLAR)
        begin
            // new sentence, drops any half-received checksum
            acc_next   = 8'h00;
            left_next  = nmea_ck_pkg::CS_NONE;
            first_next = 8'h00;
        end
        else if (rx_byte == nmea_ck_pkg::CH_STAR)
        begin
            left_next  = nmea_ck_pkg::CS_BOTH;
            first_next = 8'h00;
        end
        else if (is_cr)
        begin
            // line restart only
        end
        else if (left_reg == nmea_ck_pkg::CS_BOTH)
        begin
            first_next = rx_byte;
            left_next  = nmea_ck_pkg::CS_LAST;
        end
        else if (left_reg == nmea_ck_pkg::CS_LAST)
        begin
            emit       = 1'b1;
            left_next  = nmea_ck_pkg::CS_NONE;
            first_next = 8'h00;
        end
        else
        begin
            left_next = nmea_ck_pkg::CS_NONE;
            acc_next  = acc_reg ^ rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 8'h00;
            left_reg  <= nmea_ck_pkg::CS_NONE;
            first_reg <= 8'h00;
            pos_reg   <= 8'h00;
        end
        else if (in_accept)
        begin
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            first_reg <= first_next;
            pos_reg   <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: snapshot of checksum result and field characters
    // ------------------------------------------------------------------
    logic       s_ok_reg;
    logic [7:0] s_sum_reg;
    logic [7:0] s_chars_reg [FIELD_CHARS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (s_free)
        begin
            s_valid_reg <= in_accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_free)
        begin
            s_ok_reg  <= ok_now;
            s_sum_reg <= acc_reg;
            for (int i = 0; i < FIELD_CHARS; i++)
            begin
                s_chars_reg[i] <= snap_chars[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: number syntax scan
    // ------------------------------------------------------------------
    logic [IP_W-1:0] ip_c;
    logic [9:0]      fp_c;
    logic [9:0]      fp_scaled;
    logic [1:0]      fdig_c;
    logic            neg_c;
    logic            dot_c;
    logic            any_c;
    logic            done_c;
    logic [7:0]      ch;

    always_comb
    begin
        ip_c   = '0;
        fp_c   = 10'd0;
        fdig_c = 2'd0;
        neg_c  = 1'b0;
        dot_c  = 1'b0;
        any_c  = 1'b0;
        done_c = 1'b0;
        ch     = 8'h00;
        for (int i = 0; i < FIELD_CHARS; i++)
        begin
            ch = s_chars_reg[i];
            if (!done_c)
            begin
                if ((i == 0) && ((ch == nmea_ck_pkg::CH_PLUS)
                                 || (ch == nmea_ck_pkg::CH_MINUS)))
                begin
                    neg_c = (ch == nmea_ck_pkg::CH_MINUS);
                end
                else if (nmea_ck_pkg::is_digit(ch))
                begin
                    any_c = 1'b1;
                    if (!dot_c)
                    begin
                        ip_c = IP_W'((ip_c << 3) + (ip_c << 1) + IP_W'(ch[3:0]));
                    end
                    else if (fdig_c != 2'd3)
                    begin
                        fp_c   = 10'((fp_c << 3) + (fp_c << 1) + 10'(ch[3:0]));
                        fdig_c = fdig_c + 2'd1;
                    end
                end
                else if ((ch == nmea_ck_pkg::CH_DOT) && !dot_c)
                begin
                    dot_c = 1'b1;
                end
                else
                begin
                    done_c = 1'b1;
                end
            end
        end
    end

    // Fraction digits beyond the third are dropped; pad to thousandths
    always_comb
    begin
        case (fdig_c)
            2'd0:    fp_scaled = 10'd0;
            2'd1:    fp_scaled = 10'(fp_c * 10'd100);
            2'd2:    fp_scaled = 10'(fp_c * 10'd10);
            default: fp_scaled = fp_c;
        endcase
    end

    logic            p_ok_reg;
    logic [7:0]      p_sum_reg;
    logic [IP_W-1:0] p_ip_reg;
    logic [9:0]      p_fp_reg;
    logic            p_neg_reg;
    logic            p_any_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_free)
        begin
            p_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free)
        begin
            p_ok_reg  <= s_ok_reg;
            p_sum_reg <= s_sum_reg;
            p_ip_reg  <= ip_c;
            p_fp_reg  <= fp_scaled;
            p_neg_reg <= neg_c;
            p_any_reg <= any_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale to thousandths, sign and saturate
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]  mag;
    logic [CMP_W-1:0]  mag_ext;
    logic [CMP_W-1:0]  neg_mag;
    logic signed [24:0] value_next;

    assign mag     = MAG_W'(p_ip_reg) * MAG_W'(1000) + MAG_W'(p_fp_reg);
    assign mag_ext = CMP_W'(mag);
    assign neg_mag = ~mag_ext + CMP_W'(1);

    always_comb
    begin
        if (!p_any_reg)
        begin
            value_next = 25'sd0;
        end
        else if (p_neg_reg)
        begin
            if (mag_ext > CMP_W'(nmea_ck_pkg::MILLI_NEG_MAG))
            begin
                value_next = nmea_ck_pkg::MILLI_MIN;
            end
            else
            begin
                value_next = neg_mag[24:0];
            end
        end
        else if (mag_ext > CMP_W'(nmea_ck_pkg::MILLI_POS_MAX))
        begin
            value_next = nmea_ck_pkg::MILLI_MAX;
        end
        else
        begin
            value_next = mag_ext[24:0];
        end
    end

    logic               checksum_ok_reg;
    logic [7:0]         computed_checksum_reg;
    logic signed [24:0] field_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            checksum_ok_reg       <= p_ok_reg;
            computed_checksum_reg <= p_sum_reg;
            field_value_reg       <= value_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign checksum_ok       = checksum_ok_reg;
    assign computed_checksum = computed_checksum_reg;
    assign field_value_milli = field_value_reg;

endmodule

// ----- hdl/nmea_ck_checker.sv -----
module nmea_ck_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [7:0]         rx_byte,
    input logic               out_valid,
    input logic               out_stall,
    input logic               checksum_ok,
    input logic [7:0]         computed_checksum,
    input logic signed [24:0] field_value_milli
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(checksum_ok)
            && $stable(computed_checksum) && $stable(field_value_milli))
        else $error("stalled result changed");

    // A stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte))
        else $error("stalled input item changed");

    // Input backpressure only when the output is full and stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind nmea_checksum_field_extract nmea_ck_checker u_nmea_ck_checker (.*);

// ----- verif/nmea_checksum_field_extract_checker.sv -----
`timescale 1ns / 1ps

module nmea_checksum_field_extract_checker #(
    parameter int FIELD_CHARS = nmea_ck_pkg::FIELD_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               checksum_ok,
    input  logic [7:0]         computed_checksum,
    input  logic signed [24:0] field_value_milli,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_field_offset,
    output int                 fail_count,
    output int                 pending
);

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic               ok;
        logic [7:0]         sum;
        logic signed [24:0] milli;
    } fix_report_t;

    logic [7:0]            cur_offset;
    logic [7:0]            xor_acc;
    nmea_ck_pkg::cs_left_t chars_left;
    logic [7:0]            first_char;
    logic [7:0]            line_pos;
    logic [7:0]            field_buf [0:FIELD_CHARS-1];

    fix_report_t expected_reports [$];
    int          mismatches;

    function automatic logic [7:0] hex_of(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return nmea_ck_pkg::CH_ZERO + {4'h0, nib};
        end
        return nmea_ck_pkg::CH_HEX_BIAS + {4'h0, nib};
    endfunction

    // Decimal value of the field in thousandths; chars past the line end read as NUL
    function automatic logic signed [24:0] field_milli();
        longint     ip;
        longint     fp;
        longint     v;
        bit         neg;
        bit         dot;
        bit         any;
        bit         done;
        int         fdig;
        logic [7:0] c;
        ip   = 0;
        fp   = 0;
        neg  = 1'b0;
        dot  = 1'b0;
        any  = 1'b0;
        done = 1'b0;
        fdig = 0;
        for (int i = 0; i < FIELD_CHARS && !done; i++)
        begin
            c = (int'(cur_offset) + i < int'(line_pos)) ? field_buf[i] : 8'h00;
            if (i == 0 && (c == nmea_ck_pkg::CH_PLUS || c == nmea_ck_pkg::CH_MINUS))
            begin
                neg = (c == nmea_ck_pkg::CH_MINUS);
            end
            else if (c >= nmea_ck_pkg::CH_ZERO && c <= nmea_ck_pkg::CH_NINE)
            begin
                any = 1'b1;
                if (!dot)
                begin
                    ip = ip * 10 + longint'(c - nmea_ck_pkg::CH_ZERO);
                end
                else
                begin
                    if (fdig < 3)
                    begin
                        fp = fp * 10 + longint'(c - nmea_ck_pkg::CH_ZERO);
                    end
                    fdig++;
                end
            end
            else if (c == nmea_ck_pkg::CH_DOT && !dot)
            begin
                dot = 1'b1;
            end
            else
            begin
                done = 1'b1;
            end
        end
        if (!any)
        begin
            return '0;
        end
        while (fdig < 3)
        begin
            fp = fp * 10;
            fdig++;
        end
        v = ip * 1000 + fp;
        if (neg)
        begin
            v = -v;
        end
        if (v > longint'(nmea_ck_pkg::MILLI_POS_MAX))
        begin
            v = nmea_ck_pkg::MILLI_POS_MAX;
        end
        if (v < -longint'(nmea_ck_pkg::MILLI_NEG_MAG))
        begin
            v = -longint'(nmea_ck_pkg::MILLI_NEG_MAG);
        end
        return v[24:0];
    endfunction

    task automatic track_char(input logic [7:0] b);
        int          rel;
        fix_report_t r;
        // line position: CR restarts, saturates at 255
        if (b == nmea_ck_pkg::CH_CR)
        begin
            line_pos = '0;
        end
        else if (line_pos != 8'hFF)
        begin
            rel = int'(line_pos) - int'(cur_offset);
            if (rel >= 0 && rel < FIELD_CHARS)
            begin
                field_buf[rel] = b;
            end
            line_pos = line_pos + 8'd1;
        end

        if (b == nmea_ck_pkg::CH_DOLLAR)
        begin
            xor_acc    = '0;
            chars_left = nmea_ck_pkg::CS_NONE;
            first_char = '0;
        end
        else if (b == nmea_ck_pkg::CH_STAR)
        begin
            chars_left = nmea_ck_pkg::CS_BOTH;
            first_char = '0;
        end
        else if (b == nmea_ck_pkg::CH_CR)
        begin
            // line restart only
        end
        else if (chars_left == nmea_ck_pkg::CS_BOTH)
        begin
            first_char = b;
            chars_left = nmea_ck_pkg::CS_LAST;
        end
        else if (chars_left == nmea_ck_pkg::CS_LAST)
        begin
            r.ok    = (first_char == hex_of(xor_acc[7:4]))
                      && (b == hex_of(xor_acc[3:0]));
            r.sum   = xor_acc;
            r.milli = field_milli();
            expected_reports.push_back(r);
            chars_left = nmea_ck_pkg::CS_NONE;
            first_char = '0;
        end
        else
        begin
            chars_left = nmea_ck_pkg::CS_NONE;
            xor_acc    = xor_acc ^ b;
        end
    endtask

    task automatic check_report();
        fix_report_t want;
        if (expected_reports.size() == 0)
        begin
            if (mismatches < MAX_SHOWN)
            begin
                $display("unexpected checksum item: ok=%0b sum=%02h value=%0d",
                         checksum_ok, computed_checksum, field_value_milli);
            end
            mismatches++;
        end
        else
        begin
            want = expected_reports.pop_front();
            if (want.ok !== checksum_ok || want.sum !== computed_checksum ||
                want.milli !== field_value_milli)
            begin
                if (mismatches < MAX_SHOWN)
                begin
                    $display("expected ok=%0b sum=%02h val=%0d, got ok=%0b sum=%02h val=%0d",
                             want.ok, want.sum, $signed(want.milli),
                             checksum_ok, computed_checksum, field_value_milli);
                end
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_offset = nmea_ck_pkg::OFFSET_RESET;
            xor_acc    = '0;
            chars_left = nmea_ck_pkg::CS_NONE;
            first_char = '0;
            line_pos   = '0;
            mismatches = 0;
            expected_reports.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cur_offset = cfg_field_offset;
            end
            if (in_valid && !in_stall)
            begin
                track_char(rx_byte);
            end
            if (out_valid && !out_stall)
            begin
                check_report();
            end
        end
        fail_count <= mismatches;
        pending    <= expected_reports.size();
    end

endmodule

// ----- verif/nmea_checksum_field_extract_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict. The checker beside the block predicts and compares;
// this module only feeds characters, stalls the result side and sets the
// field offset between phases.
module nmea_checksum_field_extract_tb;

    localparam int         LIMIT         = 300000;  // cycles before giving up
    localparam int         SETTLE_CYCLES = 12;      // wait after the last result so the pipe empties
    localparam int         PHASE_ITEMS   = 150;
    localparam int         SRC_IDLE_PCT  = 80;
    localparam int         SNK_STALL_PCT = 80;
    localparam int         BOTH_PCT      = 34;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CASE_BIT      = 8'h20;   // upper -> lower case

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;
    typedef enum {CK_GOOD, CK_LOWER, CK_BAD_HI, CK_BAD_LO} ck_kind_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic               checksum_ok;
    logic [7:0]         computed_checksum;
    logic signed [24:0] field_value_milli;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_field_offset;
    int                 fail_count;
    int                 pending;

    idle_mode_t idle_mode;
    logic [7:0] cur_offset;   // offset the block holds now
    logic [7:0] gen_pos;      // line position the next char lands on
    logic [7:0] text_xor;     // running XOR since the last '$', for checksum chars
    int         bytes_sent;
    int         cycles = 0;

    // Offsets per phase; both extremes, near-saturation ones, last one random
    logic [7:0] phase_offsets [0:7] = '{8'd0, 8'd255, 8'd1, 8'd250,
                                        8'd12, 8'd3, 8'd253, 8'd0};

    always #1 clk = ~clk;

    nmea_checksum_field_extract u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .checksum_ok       (checksum_ok),
        .computed_checksum (computed_checksum),
        .field_value_milli (field_value_milli),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_field_offset  (cfg_field_offset)
    );

    nmea_checksum_field_extract_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .checksum_ok       (checksum_ok),
        .computed_checksum (computed_checksum),
        .field_value_milli (field_value_milli),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_field_offset  (cfg_field_offset),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    // Result side back-pressure, redrawn every falling edge
    always @(negedge clk)
    begin
        case (idle_mode)
            IDLE_SNK:  out_stall <= ($urandom_range(0, 99) < SNK_STALL_PCT);
            IDLE_BOTH: out_stall <= ($urandom_range(0, 99) < BOTH_PCT);
            default:   out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("nmea_checksum_field_extract: mismatch");
            $finish;
        end
    end

    // Any byte except the three framing characters
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == nmea_ck_pkg::CH_DOLLAR || c == nmea_ck_pkg::CH_STAR
               || c == nmea_ck_pkg::CH_CR)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // One item on the input channel. Entered after a rising edge, returns at
    // the rising edge that accepted it; valid stays up until the next call
    // decides to idle or present the next char.
    task automatic send_char(input logic [7:0] b);
        @(negedge clk);
        while ((idle_mode == IDLE_SRC && $urandom_range(0, 99) < SRC_IDLE_PCT) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < BOTH_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        if (b == nmea_ck_pkg::CH_CR)
        begin
            gen_pos = '0;
        end
        else if (gen_pos != 8'hFF)
        begin
            gen_pos = gen_pos + 8'd1;
        end
        if (b == nmea_ck_pkg::CH_DOLLAR)
        begin
            text_xor = '0;
        end
        else if (b != nmea_ck_pkg::CH_STAR && b != nmea_ck_pkg::CH_CR)
        begin
            text_xor = text_xor ^ b;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    // Sentence body. Chars landing in the field window are mostly number-like:
    // digits, sign, dot, space, exponent, 'x', letters of inf/nan, comma, or any plain byte.
    task automatic send_body(input int n, input bit heavy);
        logic [7:0] c;
        int         r;
        bit         in_field;
        for (int k = 0; k < n; k++)
        begin
            in_field = (int'(gen_pos) >= int'(cur_offset)) &&
                       (int'(gen_pos) < int'(cur_offset) + nmea_ck_pkg::FIELD_CHARS_DEF);
            r = $urandom_range(0, 19);
            if (in_field && heavy)
            begin
                // mostly plain digits so the largest values show up
                c = (gen_pos == cur_offset && r < 5) ? nmea_ck_pkg::CH_MINUS
                    : 8'(nmea_ck_pkg::CH_ZERO + $urandom_range(0, 9));
            end
            else if (in_field)
            begin
                if (r < 9)
                    c = 8'(nmea_ck_pkg::CH_ZERO + $urandom_range(0, 9));
                else if (r < 11)
                    c = nmea_ck_pkg::CH_DOT;
                else if (r == 11)
                    c = nmea_ck_pkg::CH_MINUS;
                else if (r == 12)
                    c = nmea_ck_pkg::CH_PLUS;
                else if (r == 13)
                    c = " ";
                else if (r == 14)
                    c = "E";
                else if (r == 15)
                    c = "x";
                else if (r == 16)
                    c = "i";
                else if (r == 17)
                    c = "n";
                else if (r == 18)
                    c = ",";
                else
                    c = plain_byte();
            end
            else
            begin
                if (r < 10)
                    c = 8'("A" + $urandom_range(0, 25));
                else if (r < 14)
                    c = 8'(nmea_ck_pkg::CH_ZERO + $urandom_range(0, 9));
                else if (r < 18)
                    c = ",";
                else
                    c = plain_byte();
            end
            send_char(c);
        end
    endtask

    // '*' and two checksum chars, optionally with one char cut in between
    task automatic send_check(input ck_kind_t kind, input bit cut, input logic [7:0] cut_char);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = nmea_ck_pkg::hex_digit(text_xor[7:4]);
        lo = nmea_ck_pkg::hex_digit(text_xor[3:0]);
        case (kind)
            CK_LOWER:
            begin
                hi = hi | CASE_BIT;
                lo = lo | CASE_BIT;
            end
            CK_BAD_HI: hi = plain_byte();
            CK_BAD_LO: lo = plain_byte();
            default: ;
        endcase
        send_char(nmea_ck_pkg::CH_STAR);
        send_char(hi);
        if (cut)
        begin
            send_char(cut_char);
        end
        send_char(lo);
    endtask

    // Drop valid, wait for every expected result, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_offset(input logic [7:0] v);
        @(negedge clk);
        cfg_valid        <= 1'b1;
        cfg_field_offset <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid  <= 1'b0;
        cur_offset = v;
    endtask

    initial
    begin
        int       start;
        int       n;
        bit       heavy;
        ck_kind_t kind;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        rx_byte          = '0;
        cfg_valid        = 1'b0;
        cfg_field_offset = '0;
        idle_mode        = IDLE_NONE;
        cur_offset       = nmea_ck_pkg::OFFSET_RESET;
        gen_pos          = '0;
        text_xor         = '0;
        bytes_sent       = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, at the reset offset of 8.
        // NUL and all-ones outside any sentence, then a new line.
        send_char(8'h00);
        send_char(8'hFF);
        send_char(nmea_ck_pkg::CH_CR);
        // Empty sentence: field window not reached yet, reads as no digits
        send_char(nmea_ck_pkg::CH_DOLLAR);
        send_check(CK_GOOD, 1'b0, nmea_ck_pkg::CH_CR);
        send_char(nmea_ck_pkg::CH_CR);
        // Negative field with one fraction digit exactly at offset 8
        send_text("$A,,,,,,-9.9");
        send_check(CK_GOOD, 1'b0, nmea_ck_pkg::CH_CR);
        // '$' between the checksum chars aborts the sentence
        send_char(nmea_ck_pkg::CH_DOLLAR);
        send_check(CK_GOOD, 1'b1, nmea_ck_pkg::CH_DOLLAR);
        // CR between the checksum chars only restarts the line
        send_char(nmea_ck_pkg::CH_DOLLAR);
        send_check(CK_GOOD, 1'b1, nmea_ck_pkg::CH_CR);
        // '*' between them restarts the checksum phase
        send_char(nmea_ck_pkg::CH_DOLLAR);
        send_check(CK_LOWER, 1'b1, nmea_ck_pkg::CH_STAR);

        // Random phases. The offset only changes right after a CR, with the
        // block drained, so the field never reads stale or unwritten chars.
        for (int phase = 0; phase < 8; phase++)
        begin
            send_char(nmea_ck_pkg::CH_CR);
            settle();
            set_offset(phase == 7 ? 8'($urandom_range(0, 255)) : phase_offsets[phase]);
            idle_mode = idle_mode_t'(phase % 4);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_ITEMS)
            begin
                n = $urandom_range(0, 99);
                if (n < 70)
                begin
                    // well-formed sentence, sometimes after a few leading chars
                    heavy = ($urandom_range(0, 2) == 0);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_body($urandom_range(1, 6), heavy);
                    end
                    send_char(nmea_ck_pkg::CH_DOLLAR);
                    // long lines push the position into saturation
                    if ($urandom_range(0, 99) < (cur_offset >= 8'd200 ? 40 : 3))
                        n = $urandom_range(200, 270);
                    else
                        n = $urandom_range(0, 20);
                    send_body(n, heavy);
                    kind = ($urandom_range(0, 9) < 7) ? CK_GOOD
                           : ck_kind_t'($urandom_range(1, 3));
                    send_check(kind, 1'b0, nmea_ck_pkg::CH_CR);
                    send_char(nmea_ck_pkg::CH_CR);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        send_char(CH_LF);
                    end
                end
                else if (n < 88)
                begin
                    // broken sentence
                    send_char(nmea_ck_pkg::CH_DOLLAR);
                    send_body($urandom_range(0, 12), 1'b0);
                    case ($urandom_range(0, 3))
                        0:       send_check(CK_GOOD, 1'b1, nmea_ck_pkg::CH_DOLLAR);
                        1:       send_check(CK_GOOD, 1'b1, nmea_ck_pkg::CH_STAR);
                        2:       send_check(CK_GOOD, 1'b1, nmea_ck_pkg::CH_CR);
                        default: send_char(nmea_ck_pkg::CH_CR);
                    endcase
                end
                else
                begin
                    // line noise, framing chars included
                    repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
                end
            end
        end

        settle();
        if (fail_count == 0)
        begin
            $display("nmea_checksum_field_extract: match");
        end
        else
        begin
            $display("nmea_checksum_field_extract: mismatch");
        end
        $finish;
    end

endmodule
